// ===== design/barrier_gate_controller_macros.svh =====
// Assertion macros for the barrier gate controller.
// Used by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef BARRIER_GATE_CONTROLLER_MACROS_SVH
`define BARRIER_GATE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define BGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BGC_ASSERT(lbl, prop, msg)
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/bgc_pkg.sv =====
// Shared types, codes and widths for the barrier gate controller.
// No dependencies; used by the channel interfaces and the top level.
package bgc_pkg;

	// Field widths
	localparam int OP_W      = 3;
	localparam int MS_W      = 20;
	localparam int TIME_W    = 32;
	localparam int CNT_W     = 8;
	localparam int GS_W      = 3;
	localparam int ERR_W     = 3;
	localparam int POS_W     = 2;
	localparam int MODE_W    = 6;
	localparam int CFG_IDX_W = 3;

	// Debounce settle time in milliseconds
	localparam logic [TIME_W-1:0] SETTLE_MS = 32'd50;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_OPEN       = 3'd1;
	localparam logic [OP_W-1:0] OP_CLOSE      = 3'd2;
	localparam logic [OP_W-1:0] OP_RESET_ERR  = 3'd3;
	localparam logic [OP_W-1:0] OP_RELAY_TEST = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_PULSE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_HOLD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TMO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DUAL_LIMIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAGS   = 3'd7;

	// Mode flag bit positions
	localparam int MODE_PULSE       = 0;
	localparam int MODE_OPEN_INV    = 1;
	localparam int MODE_CLOSE_INV   = 2;
	localparam int MODE_RELAY_INV   = 3;
	localparam int MODE_CMD_IN_ERR  = 4;
	localparam int MODE_AUTO_RECOV  = 5;

	// Reported gate state codes
	localparam logic [GS_W-1:0] GS_BOOT         = 3'd0;
	localparam logic [GS_W-1:0] GS_IDLE_UNKNOWN = 3'd1;
	localparam logic [GS_W-1:0] GS_IDLE_CLOSED  = 3'd2;
	localparam logic [GS_W-1:0] GS_OPENING      = 3'd3;
	localparam logic [GS_W-1:0] GS_OPEN_HOLD    = 3'd4;
	localparam logic [GS_W-1:0] GS_CLOSING      = 3'd5;
	localparam logic [GS_W-1:0] GS_ERROR        = 3'd6;

	// Error causes
	localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
	localparam logic [ERR_W-1:0] ERR_BOTH_LIMITS = 3'd1;
	localparam logic [ERR_W-1:0] ERR_OPEN_TMO    = 3'd2;
	localparam logic [ERR_W-1:0] ERR_OPEN_PULSE  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_CLOSE_TMO   = 3'd4;

	// Gate state machine, one-hot
	typedef enum logic [6:0] {
		ST_BOOT         = 7'b0000001,
		ST_IDLE_UNKNOWN = 7'b0000010,
		ST_IDLE_CLOSED  = 7'b0000100,
		ST_OPENING      = 7'b0001000,
		ST_OPEN_HOLD    = 7'b0010000,
		ST_CLOSING      = 7'b0100000,
		ST_ERROR        = 7'b1000000
	} gate_state_t;

	// Map the one-hot state to its reported code
	function automatic logic [GS_W-1:0] state_code(gate_state_t s);
		logic [GS_W-1:0] c;
		unique case (s)
			ST_BOOT:         c = GS_BOOT;
			ST_IDLE_UNKNOWN: c = GS_IDLE_UNKNOWN;
			ST_IDLE_CLOSED:  c = GS_IDLE_CLOSED;
			ST_OPENING:      c = GS_OPENING;
			ST_OPEN_HOLD:    c = GS_OPEN_HOLD;
			ST_CLOSING:      c = GS_CLOSING;
			ST_ERROR:        c = GS_ERROR;
			default:         c = GS_BOOT;
		endcase
		return c;
	endfunction

endpackage

// ===== design/bgc_cmd_if.sv =====
// Request channel into the barrier gate controller: ticks and commands.
// Depends on bgc_pkg for field widths.
interface bgc_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [bgc_pkg::OP_W-1:0]   op;
	logic                       open_pin_level;
	logic                       close_pin_level;
	logic [bgc_pkg::MS_W-1:0]   test_duration_ms;

	modport source (output valid, op, open_pin_level, close_pin_level, test_duration_ms,
		input ready);
	modport sink (input valid, op, open_pin_level, close_pin_level, test_duration_ms,
		output ready);
endinterface

// ===== design/bgc_status_if.sv =====
// Result channel out of the barrier gate controller: one status per request.
// Depends on bgc_pkg for field widths.
interface bgc_status_if;
	logic                        valid;
	logic                        ready;
	logic [bgc_pkg::GS_W-1:0]    gate_state;
	logic                        relay_pin;
	logic [bgc_pkg::POS_W-1:0]   position;
	logic                        accepted;
	logic [bgc_pkg::ERR_W-1:0]   error_cause;
	logic [bgc_pkg::CNT_W-1:0]   retries_used;

	modport source (output valid, gate_state, relay_pin, position, accepted, error_cause,
		retries_used, input ready);
	modport sink (input valid, gate_state, relay_pin, position, accepted, error_cause,
		retries_used, output ready);
endinterface

// ===== design/barrier_gate_controller.sv =====
// Barrier gate controller top level: debounce, millisecond clock and gate state machine.
// Depends on bgc_pkg, bgc_cmd_if, bgc_status_if and barrier_gate_controller_macros.svh.
//
// Usage:
//  cmd carries one request per handshake: a 1 ms tick, open, close, reset error or
//  relay test, together with the raw active-low open and close limit pin levels.
//  status returns exactly one result per request: gate state, relay pin level,
//  debounced position, accepted flag, last error cause and retries used.
//  cfg_wr_en/cfg_idx/cfg_data write the eight timing and mode registers; write them
//  only while no request is outstanding.
// Timing:
//  A request's result is registered at the edge that accepts it, which raises status.valid.
//  One request per cycle is sustained while status.ready is high: the whole update is one
//  pass of compare/add logic from the state registers into the result register.
//  cmd.ready is high while the result register is empty or being drained, so a
//  stalled status.ready holds one result and then stops cmd.
// Reset:
//  arst_n clears the state machine to boot, the clock, filters and counters to
//  zero and restores the register defaults; no result is pending after reset.
`include "barrier_gate_controller_macros.svh"

module barrier_gate_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	bgc_cmd_if.sink                          cmd,
	bgc_status_if.source                     status,
	input  logic                             cfg_wr_en,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [bgc_pkg::MS_W-1:0]         cfg_data
);

	localparam int TW = bgc_pkg::TIME_W;

	// Debounce filter contents
	typedef struct packed {
		logic          stable;
		logic          last;
		logic [TW-1:0] chg;
	} filt_t;

	// Configuration registers
	logic [bgc_pkg::MS_W-1:0]   open_pulse_q, open_timeout_q, open_hold_q;
	logic [bgc_pkg::MS_W-1:0]   close_tmo_q, retry_wait_q, dual_limit_q;
	logic [bgc_pkg::CNT_W-1:0]  retry_limit_q;
	logic [bgc_pkg::MODE_W-1:0] mode_q;

	// Controller state
	logic [TW-1:0]              clock_q, relay_dl_q, entry_q, retry_dl_q, both_since_q;
	bgc_pkg::gate_state_t       state_q;
	logic                       relay_q;
	logic [bgc_pkg::CNT_W-1:0]  retry_cnt_q;
	logic [bgc_pkg::ERR_W-1:0]  err_q;
	filt_t                      open_f_q, close_f_q;

	// Result register
	logic                       out_valid_q;
	logic [bgc_pkg::GS_W-1:0]   gs_q;
	logic                       relay_pin_q;
	logic [bgc_pkg::POS_W-1:0]  pos_q;
	logic                       acc_q;

	// Next-state values
	logic [TW-1:0]              nx_clock, nx_relay_dl, nx_entry, nx_retry_dl, nx_both;
	bgc_pkg::gate_state_t       nx_state;
	logic                       nx_relay, nx_acc, tick_done, allowed, pulse, opa, cla;
	logic [bgc_pkg::CNT_W-1:0]  nx_retry_cnt;
	logic [bgc_pkg::ERR_W-1:0]  nx_err;
	filt_t                      nx_open_f, nx_close_f;

	logic                       take;

	// Deadline reached: sign bit of (now - deadline) clear
	function automatic logic reached(logic [TW-1:0] now, logic [TW-1:0] dl);
		logic [TW-1:0] d;
		d = now - dl;
		return ~d[TW-1];
	endfunction

	// One debounce step on an active-low raw level
	function automatic filt_t debounce(filt_t f, logic level, logic inv, logic [TW-1:0] now);
		filt_t n;
		logic  raw;
		n   = f;
		raw = ~level ^ inv;
		if (raw != n.last) begin
			n.last = raw;
			n.chg  = now;
		end
		if (n.stable != raw && (now - n.chg) >= bgc_pkg::SETTLE_MS) begin
			n.stable = raw;
		end
		return n;
	endfunction

	assign take      = cmd.valid && cmd.ready;
	assign cmd.ready = !out_valid_q || status.ready;

	// Request update: filters first, then tick state machine or command
	always_comb begin
		nx_clock     = (cmd.op == bgc_pkg::OP_TICK) ? clock_q + 32'd1 : clock_q;
		nx_open_f    = debounce(open_f_q, cmd.open_pin_level,
			mode_q[bgc_pkg::MODE_OPEN_INV], nx_clock);
		nx_close_f   = debounce(close_f_q, cmd.close_pin_level,
			mode_q[bgc_pkg::MODE_CLOSE_INV], nx_clock);
		opa          = nx_open_f.stable;
		cla          = nx_close_f.stable;
		pulse        = mode_q[bgc_pkg::MODE_PULSE];
		allowed      = (state_q != bgc_pkg::ST_ERROR) || mode_q[bgc_pkg::MODE_CMD_IN_ERR];

		nx_state     = state_q;
		nx_relay     = relay_q;
		nx_relay_dl  = relay_dl_q;
		nx_entry     = entry_q;
		nx_retry_dl  = retry_dl_q;
		nx_both      = both_since_q;
		nx_retry_cnt = retry_cnt_q;
		nx_err       = err_q;
		nx_acc       = 1'b1;
		tick_done    = 1'b0;

		unique case (cmd.op)
			bgc_pkg::OP_TICK: begin
				// Both limits active too long
				if (opa && cla) begin
					if (nx_both == '0) begin
						nx_both = nx_clock;
					end
					if ((nx_clock - nx_both) > {{(TW-bgc_pkg::MS_W){1'b0}}, dual_limit_q}) begin
						nx_err    = bgc_pkg::ERR_BOTH_LIMITS;
						nx_relay  = 1'b0;
						nx_state  = bgc_pkg::ST_ERROR;
						nx_entry  = nx_clock;
						tick_done = 1'b1;
					end
				end else begin
					nx_both = '0;
				end

				if (!tick_done) begin
					// Relay pulse expiry outside opening
					if (nx_relay && nx_relay_dl != '0 && reached(nx_clock, nx_relay_dl) &&
						nx_state != bgc_pkg::ST_OPENING) begin
						nx_relay    = 1'b0;
						nx_relay_dl = '0;
					end

					unique case (state_q)
						bgc_pkg::ST_BOOT: begin
							nx_state = cla ? bgc_pkg::ST_IDLE_CLOSED : bgc_pkg::ST_IDLE_UNKNOWN;
							nx_entry = nx_clock;
						end
						bgc_pkg::ST_OPENING: begin
							if (pulse && reached(nx_clock, nx_relay_dl)) begin
								nx_relay = 1'b0;
							end
							if (opa) begin
								nx_relay = 1'b0;
								nx_state = bgc_pkg::ST_OPEN_HOLD;
								nx_entry = nx_clock;
							end else if (!pulse && reached(nx_clock, nx_relay_dl)) begin
								nx_err   = bgc_pkg::ERR_OPEN_TMO;
								nx_relay = 1'b0;
								nx_state = bgc_pkg::ST_ERROR;
								nx_entry = nx_clock;
							end else if (pulse && (nx_clock - nx_entry) >=
								{{(TW-bgc_pkg::MS_W){1'b0}}, open_timeout_q}) begin
								nx_err   = bgc_pkg::ERR_OPEN_PULSE;
								nx_relay = 1'b0;
								nx_state = bgc_pkg::ST_ERROR;
								nx_entry = nx_clock;
							end
						end
						bgc_pkg::ST_OPEN_HOLD: begin
							if ((nx_clock - nx_entry) >=
								{{(TW-bgc_pkg::MS_W){1'b0}}, open_hold_q}) begin
								nx_state = bgc_pkg::ST_CLOSING;
								nx_entry = nx_clock;
							end
						end
						bgc_pkg::ST_CLOSING: begin
							if (cla) begin
								nx_retry_cnt = '0;
								nx_retry_dl  = '0;
								nx_state     = bgc_pkg::ST_IDLE_CLOSED;
								nx_entry     = nx_clock;
							end else if (nx_retry_dl != '0) begin
								// Retry wait over: fire a pulse and try opening again
								if (reached(nx_clock, nx_retry_dl)) begin
									nx_retry_dl = '0;
									nx_relay    = 1'b1;
									nx_relay_dl = nx_clock +
										{{(TW-bgc_pkg::MS_W){1'b0}}, open_pulse_q};
									nx_state    = bgc_pkg::ST_OPENING;
									nx_entry    = nx_clock;
								end
							end else if ((nx_clock - nx_entry) >=
								{{(TW-bgc_pkg::MS_W){1'b0}}, close_tmo_q}) begin
								if (nx_retry_cnt < retry_limit_q) begin
									nx_retry_cnt = nx_retry_cnt + 8'd1;
									nx_retry_dl  = nx_clock +
										{{(TW-bgc_pkg::MS_W){1'b0}}, retry_wait_q};
								end else begin
									nx_err   = bgc_pkg::ERR_CLOSE_TMO;
									nx_relay = 1'b0;
									nx_state = bgc_pkg::ST_ERROR;
									nx_entry = nx_clock;
								end
							end
						end
						bgc_pkg::ST_ERROR: begin
							if (mode_q[bgc_pkg::MODE_AUTO_RECOV] && cla) begin
								nx_err       = bgc_pkg::ERR_NONE;
								nx_retry_cnt = '0;
								nx_retry_dl  = '0;
								nx_relay     = 1'b0;
								nx_state     = bgc_pkg::ST_IDLE_CLOSED;
								nx_entry     = nx_clock;
							end
						end
						default: begin
						end
					endcase

					// Pulse-mode relay expiry while opening
					if (nx_relay && nx_relay_dl != '0 && reached(nx_clock, nx_relay_dl) &&
						pulse && nx_state == bgc_pkg::ST_OPENING) begin
						nx_relay    = 1'b0;
						nx_relay_dl = '0;
					end
				end
			end
			bgc_pkg::OP_OPEN: begin
				if (allowed) begin
					nx_retry_cnt = '0;
					nx_retry_dl  = '0;
					nx_relay     = 1'b1;
					nx_relay_dl  = nx_clock + {{(TW-bgc_pkg::MS_W){1'b0}},
						(pulse ? open_pulse_q : open_timeout_q)};
					nx_state     = bgc_pkg::ST_OPENING;
					nx_entry     = nx_clock;
				end else begin
					nx_acc = 1'b0;
				end
			end
			bgc_pkg::OP_CLOSE: begin
				if (allowed) begin
					nx_relay    = 1'b0;
					nx_retry_dl = '0;
					nx_state    = bgc_pkg::ST_CLOSING;
					nx_entry    = nx_clock;
				end else begin
					nx_acc = 1'b0;
				end
			end
			bgc_pkg::OP_RESET_ERR: begin
				nx_err       = bgc_pkg::ERR_NONE;
				nx_retry_cnt = '0;
				nx_retry_dl  = '0;
				nx_relay     = 1'b0;
				nx_state     = cla ? bgc_pkg::ST_IDLE_CLOSED : bgc_pkg::ST_IDLE_UNKNOWN;
				nx_entry     = nx_clock;
			end
			bgc_pkg::OP_RELAY_TEST: begin
				nx_relay    = 1'b1;
				nx_relay_dl = nx_clock + {{(TW-bgc_pkg::MS_W){1'b0}}, cmd.test_duration_ms};
			end
			default: begin
				nx_acc = 1'b0;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_pulse_q   <= 20'd500;
			open_timeout_q <= 20'd20000;
			open_hold_q    <= 20'd10000;
			close_tmo_q    <= 20'd20000;
			retry_wait_q   <= 20'd2000;
			dual_limit_q   <= 20'd1000;
			retry_limit_q  <= 8'd2;
			mode_q         <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				bgc_pkg::CFG_OPEN_PULSE:   open_pulse_q   <= cfg_data;
				bgc_pkg::CFG_OPEN_TIMEOUT: open_timeout_q <= cfg_data;
				bgc_pkg::CFG_OPEN_HOLD:    open_hold_q    <= cfg_data;
				bgc_pkg::CFG_CLOSE_TMO:    close_tmo_q    <= cfg_data;
				bgc_pkg::CFG_RETRY_WAIT:   retry_wait_q   <= cfg_data;
				bgc_pkg::CFG_DUAL_LIMIT:   dual_limit_q   <= cfg_data;
				bgc_pkg::CFG_RETRY_LIMIT:  retry_limit_q  <= cfg_data[bgc_pkg::CNT_W-1:0];
				bgc_pkg::CFG_MODE_FLAGS:   mode_q         <= cfg_data[bgc_pkg::MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Controller state, updated once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q      <= '0;
			state_q      <= bgc_pkg::ST_BOOT;
			relay_q      <= 1'b0;
			relay_dl_q   <= '0;
			entry_q      <= '0;
			retry_dl_q   <= '0;
			both_since_q <= '0;
			retry_cnt_q  <= '0;
			err_q        <= bgc_pkg::ERR_NONE;
			open_f_q     <= '0;
			close_f_q    <= '0;
		end else if (take) begin
			clock_q      <= nx_clock;
			state_q      <= nx_state;
			relay_q      <= nx_relay;
			relay_dl_q   <= nx_relay_dl;
			entry_q      <= nx_entry;
			retry_dl_q   <= nx_retry_dl;
			both_since_q <= nx_both;
			retry_cnt_q  <= nx_retry_cnt;
			err_q        <= nx_err;
			open_f_q     <= nx_open_f;
			close_f_q    <= nx_close_f;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			gs_q        <= bgc_pkg::state_code(nx_state);
			relay_pin_q <= nx_relay ^ mode_q[bgc_pkg::MODE_RELAY_INV];
			pos_q       <= {nx_close_f.stable, nx_open_f.stable};
			acc_q       <= nx_acc;
		end
	end

	assign status.valid        = out_valid_q;
	assign status.gate_state   = gs_q;
	assign status.relay_pin    = relay_pin_q;
	assign status.position     = pos_q;
	assign status.accepted     = acc_q;
	assign status.error_cause  = err_q;
	assign status.retries_used = retry_cnt_q;

	// Checks; the cause outlives the error state when commands are allowed in error
	`BGC_ASSERT(a_error_has_cause, (state_q != bgc_pkg::ST_ERROR) || (err_q != bgc_pkg::ERR_NONE), "error state without a cause")
	`BGC_ASSERT_NEXT(a_take_gives_result, take, status.valid, "accepted request produced no result")
	`BGC_ASSERT_NEXT(a_hold_without_request, !take, $stable(state_q) && $stable(clock_q) && $stable(retry_cnt_q), "state moved without a request")

endmodule

// ===== test/tb_barrier_gate_controller.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for barrier_gate_controller: request and status channel traffic
// checked against a cycle-free behavioral model of the gate controller.
// Depends on bgc_pkg, bgc_cmd_if, bgc_status_if and the design top level.
module tb_barrier_gate_controller;
	import bgc_pkg::*;

	localparam int SEGMENTS    = 6;
	localparam int ZERO_SEG    = 1;
	localparam int MAX_SEG     = 3;
	localparam int SEG_ITEMS   = 115;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 5;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            open_level;
		logic            close_level;
		logic [MS_W-1:0] test_ms;
	} gate_request_t;

	typedef struct packed {
		logic [GS_W-1:0]  gate_state;
		logic             relay_pin;
		logic [POS_W-1:0] position;
		logic             accepted;
		logic [ERR_W-1:0] error_cause;
		logic [CNT_W-1:0] retries_used;
	} gate_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [MS_W-1:0] cfg_data;

	bgc_cmd_if cmd_ch();
	bgc_status_if status_ch();

	barrier_gate_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.status    (status_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	gate_request_t gate_requests[$];
	gate_status_t expected_status[$];
	int send_idle_pct, recv_idle_pct;
	int items_made;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	// Mirrored controller state
	logic [TIME_W-1:0] now_ms, relay_due, entered_ms, retry_due, dual_since;
	logic [TIME_W-1:0] open_changed_ms, close_changed_ms;
	logic [GS_W-1:0]   gate_code;
	logic [ERR_W-1:0]  fault;
	logic [CNT_W-1:0]  retries;
	logic              relay_on;
	logic              open_stable, open_raw_last, close_stable, close_raw_last;

	// Mirrored register file
	logic [MS_W-1:0]   pulse_ms, open_tmo_ms, hold_ms, close_tmo_ms, retry_wait_ms, dual_ms;
	logic [CNT_W-1:0]  retry_limit;
	logic [MODE_W-1:0] flags;

	function automatic void reset_model();
		pulse_ms = 20'd500;
		open_tmo_ms = 20'd20000;
		hold_ms = 20'd10000;
		close_tmo_ms = 20'd20000;
		retry_wait_ms = 20'd2000;
		dual_ms = 20'd1000;
		retry_limit = 8'd2;
		flags = '0;
		now_ms = '0;
		relay_due = '0;
		entered_ms = '0;
		retry_due = '0;
		dual_since = '0;
		gate_code = GS_BOOT;
		fault = ERR_NONE;
		retries = '0;
		relay_on = 1'b0;
		open_stable = 1'b0;
		open_raw_last = 1'b0;
		open_changed_ms = '0;
		close_stable = 1'b0;
		close_raw_last = 1'b0;
		close_changed_ms = '0;
	endfunction

	// Wrap-safe "deadline has passed" test on the ms clock
	function automatic logic due(input logic [TIME_W-1:0] deadline);
		logic [TIME_W-1:0] diff;
		diff = now_ms - deadline;
		return !diff[TIME_W-1];
	endfunction

	function automatic void debounce(input logic level, input logic inv, inout logic stable,
		inout logic last, inout logic [TIME_W-1:0] since);
		logic raw;
		logic [TIME_W-1:0] age;
		raw = ~level ^ inv;
		if (raw != last) begin
			last = raw;
			since = now_ms;
		end
		age = now_ms - since;
		if (stable != raw && age >= SETTLE_MS)
			stable = raw;
	endfunction

	function automatic void enter_state(input logic [GS_W-1:0] code);
		gate_code = code;
		entered_ms = now_ms;
	endfunction

	function automatic void trip(input logic [ERR_W-1:0] cause);
		fault = cause;
		relay_on = 1'b0;
		enter_state(GS_ERROR);
	endfunction

	function automatic void recover();
		fault = ERR_NONE;
		retries = '0;
		retry_due = '0;
		relay_on = 1'b0;
		enter_state(close_stable ? GS_IDLE_CLOSED : GS_IDLE_UNKNOWN);
	endfunction

	// One millisecond of gate state machine
	function automatic void run_tick();
		logic pulse, at_open, at_close;
		logic [TIME_W-1:0] span;
		pulse = flags[MODE_PULSE];
		at_open = open_stable;
		at_close = close_stable;

		// both limits active for too long
		if (at_open && at_close) begin
			if (dual_since == '0)
				dual_since = now_ms;
			span = now_ms - dual_since;
			if (span > dual_ms) begin
				trip(ERR_BOTH_LIMITS);
				return;
			end
		end else begin
			dual_since = '0;
		end

		if (relay_on && relay_due != '0 && due(relay_due) && gate_code != GS_OPENING) begin
			relay_on = 1'b0;
			relay_due = '0;
		end

		span = now_ms - entered_ms;
		case (gate_code)
			GS_BOOT: begin
				enter_state(at_close ? GS_IDLE_CLOSED : GS_IDLE_UNKNOWN);
			end
			GS_OPENING: begin
				if (pulse && due(relay_due))
					relay_on = 1'b0;
				if (at_open) begin
					relay_on = 1'b0;
					enter_state(GS_OPEN_HOLD);
				end else if (!pulse && due(relay_due)) begin
					trip(ERR_OPEN_TMO);
				end else if (pulse && span >= open_tmo_ms) begin
					trip(ERR_OPEN_PULSE);
				end
			end
			GS_OPEN_HOLD: begin
				if (span >= hold_ms)
					enter_state(GS_CLOSING);
			end
			GS_CLOSING: begin
				if (at_close) begin
					retries = '0;
					retry_due = '0;
					enter_state(GS_IDLE_CLOSED);
				end else if (retry_due != '0) begin
					// retry pulse once the wait is over
					if (due(retry_due)) begin
						retry_due = '0;
						relay_on = 1'b1;
						relay_due = now_ms + pulse_ms;
						enter_state(GS_OPENING);
					end
				end else if (span >= close_tmo_ms) begin
					if (retries < retry_limit) begin
						retries = retries + 8'd1;
						retry_due = now_ms + retry_wait_ms;
					end else begin
						trip(ERR_CLOSE_TMO);
					end
				end
			end
			GS_ERROR: begin
				if (flags[MODE_AUTO_RECOV] && at_close)
					recover();
			end
			default: ;
		endcase

		if (relay_on && relay_due != '0 && due(relay_due) && pulse && gate_code == GS_OPENING) begin
			relay_on = 1'b0;
			relay_due = '0;
		end
	endfunction

	// Apply one request to the mirrored state and return the status it produces
	function automatic gate_status_t next_gate_status(input gate_request_t rq);
		gate_status_t res;
		logic allowed, acc;
		allowed = gate_code != GS_ERROR || flags[MODE_CMD_IN_ERR];
		acc = 1'b1;
		if (rq.op == OP_TICK)
			now_ms = now_ms + 1;
		debounce(rq.open_level, flags[MODE_OPEN_INV], open_stable, open_raw_last, open_changed_ms);
		debounce(rq.close_level, flags[MODE_CLOSE_INV], close_stable, close_raw_last,
			close_changed_ms);

		case (rq.op)
			OP_TICK: run_tick();
			OP_OPEN: begin
				if (allowed) begin
					retries = '0;
					retry_due = '0;
					relay_on = 1'b1;
					relay_due = now_ms + (flags[MODE_PULSE] ? pulse_ms : open_tmo_ms);
					enter_state(GS_OPENING);
				end else begin
					acc = 1'b0;
				end
			end
			OP_CLOSE: begin
				if (allowed) begin
					relay_on = 1'b0;
					retry_due = '0;
					enter_state(GS_CLOSING);
				end else begin
					acc = 1'b0;
				end
			end
			OP_RESET_ERR: recover();
			OP_RELAY_TEST: begin
				relay_on = 1'b1;
				relay_due = now_ms + rq.test_ms;
			end
			default: acc = 1'b0;
		endcase

		res.gate_state = gate_code;
		res.relay_pin = relay_on ^ flags[MODE_RELAY_INV];
		res.position = {close_stable, open_stable};
		res.accepted = acc;
		res.error_cause = fault;
		res.retries_used = retries;
		return res;
	endfunction

	// Request driver: predicts each accepted request, then offers the next one
	always @(posedge clk) begin : drive_requests
		gate_request_t rq, sent;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				sent.op = cmd_ch.op;
				sent.open_level = cmd_ch.open_pin_level;
				sent.close_level = cmd_ch.close_pin_level;
				sent.test_ms = cmd_ch.test_duration_ms;
				expected_status.push_back(next_gate_status(sent));
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (gate_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					rq = gate_requests.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.op <= rq.op;
					cmd_ch.open_pin_level <= rq.open_level;
					cmd_ch.close_pin_level <= rq.close_level;
					cmd_ch.test_duration_ms <= rq.test_ms;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Status monitor: compare each result with the oldest prediction
	always @(posedge clk) begin : check_status
		gate_status_t want;
		if (arst_n) begin
			if (status_ch.valid && status_ch.ready) begin
				if (expected_status.size() == 0) begin
					$error("status returned with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_status.pop_front();
					if (status_ch.gate_state !== want.gate_state) begin
						$error("gate_state mismatch: expected %0d, got %0d",
							want.gate_state, status_ch.gate_state);
						mismatch_count++;
					end
					if (status_ch.relay_pin !== want.relay_pin) begin
						$error("relay_pin mismatch: expected %0d, got %0d",
							want.relay_pin, status_ch.relay_pin);
						mismatch_count++;
					end
					if (status_ch.position !== want.position) begin
						$error("position mismatch: expected %0d, got %0d",
							want.position, status_ch.position);
						mismatch_count++;
					end
					if (status_ch.accepted !== want.accepted) begin
						$error("accepted mismatch: expected %0d, got %0d",
							want.accepted, status_ch.accepted);
						mismatch_count++;
					end
					if (status_ch.error_cause !== want.error_cause) begin
						$error("error_cause mismatch: expected %0d, got %0d",
							want.error_cause, status_ch.error_cause);
						mismatch_count++;
					end
					if (status_ch.retries_used !== want.retries_used) begin
						$error("retries_used mismatch: expected %0d, got %0d",
							want.retries_used, status_ch.retries_used);
						mismatch_count++;
					end
				end
			end
			status_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Queue one request; limit activity is given as active/inactive and mapped to pin level
	task automatic queue_item(input logic [OP_W-1:0] op, input logic open_act,
		input logic close_act, input logic [MS_W-1:0] dur);
		gate_request_t rq;
		rq.op = op;
		rq.open_level = ~(open_act ^ flags[MODE_OPEN_INV]);
		rq.close_level = ~(close_act ^ flags[MODE_CLOSE_INV]);
		rq.test_ms = dur;
		gate_requests.push_back(rq);
		if (op <= OP_RELAY_TEST)
			items_made++;
	endtask

	// Run of ticks with the limits held, with the odd one-tick glitch on the open switch
	task automatic queue_ticks(input int n, input logic open_act, input logic close_act);
		logic glitch;
		for (int i = 0; i < n; i++) begin
			glitch = ($urandom_range(99) < 3);
			queue_item(OP_TICK, open_act ^ glitch, close_act, MS_W'($urandom));
		end
	endtask

	// Relay test length: mostly short, sometimes the field extremes
	function automatic logic [MS_W-1:0] test_len();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return MS_W'($urandom_range(80));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			CFG_OPEN_PULSE:   pulse_ms = val;
			CFG_OPEN_TIMEOUT: open_tmo_ms = val;
			CFG_OPEN_HOLD:    hold_ms = val;
			CFG_CLOSE_TMO:    close_tmo_ms = val;
			CFG_RETRY_WAIT:   retry_wait_ms = val;
			CFG_DUAL_LIMIT:   dual_ms = val;
			CFG_RETRY_LIMIT:  retry_limit = val[CNT_W-1:0];
			CFG_MODE_FLAGS:   flags = val[MODE_W-1:0];
			default: ;
		endcase
	endtask

	// Register set for one segment: short timings, all zero or all ones; mode flags random, all set or all clear
	task automatic configure(input int seg);
		logic [MS_W-1:0] v;
		for (int i = CFG_OPEN_PULSE; i <= CFG_DUAL_LIMIT; i++) begin
			if (seg == ZERO_SEG)
				v = '0;
			else if (seg == MAX_SEG)
				v = '1;
			else begin
				case (CFG_IDX_W'(i))
					CFG_OPEN_PULSE:   v = MS_W'($urandom_range(40, 1));
					CFG_OPEN_TIMEOUT: v = MS_W'($urandom_range(150, 20));
					CFG_OPEN_HOLD:    v = MS_W'($urandom_range(60));
					CFG_CLOSE_TMO:    v = MS_W'($urandom_range(90, 10));
					CFG_RETRY_WAIT:   v = MS_W'($urandom_range(25));
					default:          v = MS_W'($urandom_range(80));
				endcase
			end
			write_reg(CFG_IDX_W'(i), v);
		end
		if (seg == ZERO_SEG)
			write_reg(CFG_RETRY_LIMIT, '0);
		else if (seg == MAX_SEG)
			write_reg(CFG_RETRY_LIMIT, MS_W'({CNT_W{1'b1}}));
		else
			write_reg(CFG_RETRY_LIMIT, MS_W'($urandom_range(3)));
		if (seg == SEGMENTS - 2)
			write_reg(CFG_MODE_FLAGS, MS_W'({MODE_W{1'b1}}));
		else if (seg == SEGMENTS - 1)
			write_reg(CFG_MODE_FLAGS, '0);
		else
			write_reg(CFG_MODE_FLAGS, MS_W'($urandom_range(2**MODE_W - 1)));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One stretch of gate traffic, mostly physically plausible switch sequences
	task automatic run_scenario();
		int n;
		logic a, c;
		case ($urandom_range(9))
			0, 1, 2: begin
				// full open / hold / close cycle
				queue_item(OP_OPEN, 1'b0, 1'b1, MS_W'($urandom));
				queue_ticks($urandom_range(8, 1), 1'b0, 1'b1);
				queue_ticks($urandom_range(25, 3), 1'b0, 1'b0);
				queue_ticks($urandom_range(90, 30), 1'b1, 1'b0);
				if ($urandom_range(3) == 0)
					queue_item(OP_CLOSE, 1'b1, 1'b0, MS_W'($urandom));
				queue_ticks($urandom_range(25, 3), 1'b0, 1'b0);
				queue_ticks($urandom_range(75, 30), 1'b0, 1'b1);
			end
			3, 4: begin
				// closing that stalls in transit: timeouts and retry pulses
				queue_item(OP_OPEN, 1'b0, 1'b1, MS_W'($urandom));
				queue_ticks($urandom_range(70, 30), 1'b1, 1'b0);
				queue_item(OP_CLOSE, 1'b1, 1'b0, MS_W'($urandom));
				queue_ticks($urandom_range(150, 30), 1'b0, 1'b0);
				if ($urandom_range(1)) begin
					queue_item(OP_CLOSE, 1'b0, 1'b0, MS_W'($urandom));
					queue_ticks($urandom_range(60, 10), 1'b0, 1'b0);
				end
				if ($urandom_range(1))
					queue_item(OP_RESET_ERR, 1'b0, 1'b0, MS_W'($urandom));
				queue_ticks($urandom_range(60, 10), 1'b0, 1'b1);
			end
			5: begin
				// open limit never reached
				c = $urandom_range(1);
				queue_item(OP_OPEN, 1'b0, c, MS_W'($urandom));
				queue_ticks($urandom_range(160, 20), 1'b0, 1'b0);
			end
			6: begin
				// both limits active
				queue_ticks($urandom_range(120, 30), 1'b1, 1'b1);
				queue_ticks($urandom_range(60, 30), 1'b0, 1'b1);
			end
			7: begin
				// command burst, typically landing in error or idle
				n = $urandom_range(10, 4);
				a = $urandom_range(1);
				c = $urandom_range(1);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(3))
						0: queue_item(OP_OPEN, a, c, MS_W'($urandom));
						1: queue_item(OP_CLOSE, a, c, MS_W'($urandom));
						2: queue_item(OP_RESET_ERR, a, c, MS_W'($urandom));
						default: queue_item(OP_RELAY_TEST, a, c, test_len());
					endcase
					queue_ticks($urandom_range(4), a, c);
				end
			end
			8: begin
				// noise: any op code and any pin levels
				n = $urandom_range(25, 8);
				for (int i = 0; i < n; i++)
					queue_item(OP_W'($urandom_range(2**OP_W - 1)), $urandom_range(1),
						$urandom_range(1), MS_W'($urandom));
			end
			default: begin
				// relay test then let it run out
				a = $urandom_range(1);
				c = $urandom_range(1);
				queue_item(OP_RELAY_TEST, a, c, test_len());
				queue_ticks($urandom_range(70, 5), a, c);
			end
		endcase
	endtask

	// Wait until every request is accepted and every status returned
	task automatic drain();
		while (gate_requests.size() != 0 || cmd_ch.valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	initial begin : stimulus
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_TICK;
		cmd_ch.open_pin_level = 1'b1;
		cmd_ch.close_pin_level = 1'b1;
		cmd_ch.test_duration_ms = '0;
		status_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_idx = CFG_OPEN_PULSE;
		cfg_data = '0;
		reset_model();
		send_idle_pct = 8;
		recv_idle_pct = 74;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset register values, every op, field extremes.
		// A relay test of zero length at clock zero gives a deadline that reads as none.
		queue_item(OP_RELAY_TEST, 1'b0, 1'b0, '0);
		queue_item(OP_TICK, 1'b0, 1'b0, '0);
		queue_item(OP_OPEN, 1'b0, 1'b0, '1);
		queue_item(OP_TICK, 1'b1, 1'b1, 20'hAAAAA);
		queue_item(OP_CLOSE, 1'b1, 1'b0, 20'h55555);
		queue_item(OP_RESET_ERR, 1'b0, 1'b1, '0);
		queue_item(OP_RELAY_TEST + 3'd1, 1'b0, 1'b0, '0);
		queue_item(OP_RELAY_TEST + 3'd3, 1'b1, 1'b1, '1);
		queue_item(OP_RELAY_TEST, 1'b0, 1'b0, '1);
		queue_item(OP_TICK, 1'b0, 1'b0, '1);
		queue_item(OP_RELAY_TEST + 3'd2, 1'b1, 1'b0, '0);
		queue_item(OP_OPEN, 1'b0, 1'b1, '0);
		queue_item(OP_TICK, 1'b0, 1'b1, '0);
		queue_item(OP_RELAY_TEST, 1'b0, 1'b1, 20'd1);
		queue_item(OP_TICK, 1'b0, 1'b1, '0);
		queue_item(OP_TICK, 1'b0, 1'b1, '0);
		queue_item(OP_CLOSE, 1'b0, 1'b1, '0);
		queue_item(OP_TICK, 1'b0, 1'b1, '0);
		drain();

		// Random segments, each with its own register set and one of three idle profiles
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 8;
				recv_idle_pct = 74;
			end else if (seg < 4) begin
				send_idle_pct = 74;
				recv_idle_pct = 8;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			configure(seg);
			items_made = 0;
			while (items_made < SEG_ITEMS)
				run_scenario();
			drain();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/bgc_pkg.sv
design/bgc_cmd_if.sv
design/bgc_status_if.sv
design/barrier_gate_controller.sv
test/tb_barrier_gate_controller.sv
